// ===== design/dop_pkg.sv =====
// Shared types and constants for the ditroff output parser.
// Holds the event kinds, the result record and the port widths.
// No dependencies.
package dop_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int NAME_CHARS_DEF  = 8;

    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 3;
    localparam int CODE_W     = 8;
    localparam int NAME_OUT_W = 64;
    localparam int POS_W      = 24;
    localparam int FONT_W     = 8;
    localparam int SIZE_W     = 10;
    localparam int PAGE_W     = 16;

    localparam int DATA_BITS  = CODE_W + NAME_OUT_W + 2 * POS_W + FONT_W + SIZE_W + PAGE_W;
    localparam int TDATA_W    = ((DATA_BITS + 7) / 8) * 8;
    localparam int IN_TDATA_W = BYTE_W;
    localparam int TUSER_W    = KIND_W;

    localparam int OUTQ_DEPTH = 4;

    typedef enum logic [KIND_W-1:0] {
        EV_CHAR    = 3'd0,
        EV_SPECIAL = 3'd1,
        EV_SPACE   = 3'd2,
        EV_NEWLINE = 3'd3,
        EV_PAGE    = 3'd4,
        EV_ERROR   = 3'd5
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t              kind;
        logic [CODE_W-1:0]     code;
        logic [NAME_OUT_W-1:0] name;
        logic [POS_W-1:0]      x_pos;
        logic [POS_W-1:0]      y_pos;
        logic [FONT_W-1:0]     font;
        logic [SIZE_W-1:0]     size;
        logic [PAGE_W-1:0]     page;
        logic                  last;
    } res_t;

endpackage

// ===== design/dop_core.sv =====
// Parser state and per-byte update logic of the ditroff output parser.
// Produces up to two result records per processed byte.
// Depends on dop_pkg.
module dop_core
    import dop_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int NAME_CHARS  = NAME_CHARS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [BYTE_W-1:0] byte_in,
    output res_t              res0,
    output res_t              res1,
    output logic [1:0]        res_cnt
);

    localparam int MW     = COORD_WIDTH - 1;
    localparam int AW     = MW + 4;
    localparam int SW     = COORD_WIDTH + 2;
    localparam int EXT_W  = (COORD_WIDTH > POS_W) ? COORD_WIDTH : POS_W;
    localparam int NAME_W = NAME_CHARS * 8;
    localparam int LEN_W  = $clog2(NAME_CHARS + 1);

    localparam logic [MW-1:0]        MAG_MAX = {MW{1'b1}};
    localparam logic signed [SW-1:0] CMAX_S  = SW'(MAG_MAX);
    localparam logic signed [SW-1:0] CMIN_S  = ~CMAX_S;
    localparam logic signed [SW-1:0] SIZE_HI = SW'((1 << SIZE_W) - 1);
    localparam logic signed [SW-1:0] FONT_HI = SW'((1 << FONT_W) - 1);
    localparam logic signed [SW-1:0] PAGE_HI = SW'((1 << PAGE_W) - 1);

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LW    = 8'h77;
    localparam logic [7:0] CH_LC    = 8'h63;
    localparam logic [7:0] CH_UC    = 8'h43;
    localparam logic [7:0] CH_UD    = 8'h44;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LS    = 8'h73;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UH    = 8'h48;
    localparam logic [7:0] CH_LH    = 8'h68;
    localparam logic [7:0] CH_UV    = 8'h56;
    localparam logic [7:0] CH_LV    = 8'h76;
    localparam logic [7:0] CH_LP    = 8'h70;
    localparam logic [7:0] CH_LN    = 8'h6E;

    typedef enum logic [7:0] {
        MODE_CMD      = 8'b0000_0001,
        MODE_MOTION   = 8'b0000_0010,
        MODE_CHAR     = 8'b0000_0100,
        MODE_NAME_WS  = 8'b0000_1000,
        MODE_NAME     = 8'b0001_0000,
        MODE_SKIP     = 8'b0010_0000,
        MODE_NUM_WS   = 8'b0100_0000,
        MODE_NUM_BODY = 8'b1000_0000
    } mode_t;

    typedef enum logic [2:0] {
        TGT_NONE = 3'd0,
        TGT_SIZE = 3'd1,
        TGT_FONT = 3'd2,
        TGT_HABS = 3'd3,
        TGT_HREL = 3'd4,
        TGT_VABS = 3'd5,
        TGT_VREL = 3'd6,
        TGT_PAGE = 3'd7
    } tgt_t;

    mode_t                   mode_reg, mode_next;
    tgt_t                    tgt_reg, tgt_next;
    logic [FONT_W-1:0]       font_reg, font_next;
    logic [SIZE_W-1:0]       size_reg, size_next;
    logic signed [COORD_WIDTH-1:0] pen_x_reg, pen_x_next;
    logic signed [COORD_WIDTH-1:0] pen_y_reg, pen_y_next;
    logic [MW-1:0]           val_reg, val_next;
    logic                    neg_reg, neg_next;
    logic                    seen_reg, seen_next;
    logic [3:0]              tens_reg, tens_next;
    logic [NAME_W-1:0]       name_reg, name_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic                    halted_reg, halted_next;

    logic                    is_space, is_digit, do_cmd;
    logic [3:0]              dval;
    logic [AW-1:0]           prod;
    logic signed [9:0]       mdelta;
    logic signed [SW-1:0]    nv;
    res_t                    res_v [2];
    logic [1:0]              cnt_v;

    function automatic logic [POS_W-1:0] pos_out(input logic signed [COORD_WIDTH-1:0] p);
        logic [EXT_W-1:0] e;
        e = EXT_W'(p);
        return e[POS_W-1:0];
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] s);
        logic signed [COORD_WIDTH-1:0] r;
        if (s > CMAX_S)
        begin
            r = CMAX_S[COORD_WIDTH-1:0];
        end
        else if (s < CMIN_S)
        begin
            r = CMIN_S[COORD_WIDTH-1:0];
        end
        else
        begin
            r = s[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic res_t mk_res(
        input ev_kind_t                      kind,
        input logic [CODE_W-1:0]             code,
        input logic [NAME_W-1:0]             name,
        input logic signed [COORD_WIDTH-1:0] px,
        input logic signed [COORD_WIDTH-1:0] py,
        input logic [FONT_W-1:0]             fnt,
        input logic [SIZE_W-1:0]             sz,
        input logic [PAGE_W-1:0]             pg
    );
        res_t r;
        r.kind  = kind;
        r.code  = code;
        r.name  = NAME_OUT_W'(name);
        r.x_pos = pos_out(px);
        r.y_pos = pos_out(py);
        r.font  = fnt;
        r.size  = sz;
        r.page  = pg;
        r.last  = 1'b0;
        return r;
    endfunction

    assign is_space = (byte_in == CH_SP) || (byte_in == CH_TAB) ||
                      ((byte_in >= CH_NL) && (byte_in <= CH_CR));
    assign is_digit = (byte_in >= CH_0) && (byte_in <= CH_9);
    assign dval     = byte_in[3:0];
    assign prod     = AW'({val_reg, 3'b000}) + AW'({val_reg, 1'b0}) + AW'(dval);
    assign mdelta   = $signed({2'b00, byte_in}) - 10'sd48 +
                      $signed(10'({tens_reg, 3'b000}) + 10'({tens_reg, 1'b0}));
    assign nv       = neg_reg ? -SW'(val_reg) : SW'(val_reg);

    always_comb
    begin
        mode_next   = mode_reg;
        tgt_next    = tgt_reg;
        font_next   = font_reg;
        size_next   = size_reg;
        pen_x_next  = pen_x_reg;
        pen_y_next  = pen_y_reg;
        val_next    = val_reg;
        neg_next    = neg_reg;
        seen_next   = seen_reg;
        tens_next   = tens_reg;
        name_next   = name_reg;
        len_next    = len_reg;
        halted_next = halted_reg;
        do_cmd      = 1'b0;
        cnt_v       = 2'd0;
        res_v[0]    = '0;
        res_v[1]    = '0;

        if (fire && !halted_reg)
        begin
            case (mode_reg)
                MODE_MOTION:
                begin
                    pen_x_next = sat(SW'(pen_x_reg) + SW'(mdelta));
                    mode_next  = MODE_CHAR;
                end
                MODE_CHAR:
                begin
                    res_v[cnt_v[0]] = mk_res(EV_CHAR, byte_in, '0, pen_x_next, pen_y_next,
                                             font_next, size_next, '0);
                    cnt_v     = cnt_v + 2'd1;
                    mode_next = MODE_CMD;
                end
                MODE_NAME_WS:
                begin
                    if (!is_space)
                    begin
                        name_next = NAME_W'(byte_in);
                        len_next  = LEN_W'(1);
                        mode_next = MODE_NAME;
                    end
                end
                MODE_NAME:
                begin
                    if (is_space)
                    begin
                        res_v[cnt_v[0]] = mk_res(EV_SPECIAL, '0, name_reg, pen_x_next,
                                                 pen_y_next, font_next, size_next, '0);
                        cnt_v     = cnt_v + 2'd1;
                        mode_next = MODE_CMD;
                    end
                    else if (len_reg < LEN_W'(NAME_CHARS))
                    begin
                        for (int i = 0; i < NAME_CHARS; i++)
                        begin
                            if (len_reg == LEN_W'(i))
                            begin
                                name_next[8*i +: 8] = byte_in;
                            end
                        end
                        len_next = len_reg + LEN_W'(1);
                    end
                end
                MODE_SKIP:
                begin
                    if (byte_in == CH_NL)
                    begin
                        mode_next = MODE_CMD;
                    end
                end
                MODE_NUM_WS:
                begin
                    if (!is_space)
                    begin
                        if ((byte_in == CH_PLUS) || (byte_in == CH_MINUS))
                        begin
                            neg_next  = (byte_in == CH_MINUS);
                            mode_next = MODE_NUM_BODY;
                        end
                        else if (is_digit)
                        begin
                            val_next  = (prod > AW'(MAG_MAX)) ? MAG_MAX : prod[MW-1:0];
                            seen_next = 1'b1;
                            mode_next = MODE_NUM_BODY;
                        end
                        else
                        begin
                            res_v[cnt_v[0]] = mk_res(EV_ERROR, '0, '0, pen_x_next, pen_y_next,
                                                     font_next, size_next, '0);
                            cnt_v       = cnt_v + 2'd1;
                            halted_next = 1'b1;
                        end
                    end
                end
                MODE_NUM_BODY:
                begin
                    if (is_digit)
                    begin
                        val_next  = (prod > AW'(MAG_MAX)) ? MAG_MAX : prod[MW-1:0];
                        seen_next = 1'b1;
                    end
                    else if (seen_reg)
                    begin
                        mode_next = MODE_CMD;
                        case (tgt_reg)
                            TGT_SIZE:
                            begin
                                size_next = (nv < 0) ? '0 :
                                            (nv > SIZE_HI) ? SIZE_HI[SIZE_W-1:0] : nv[SIZE_W-1:0];
                            end
                            TGT_FONT:
                            begin
                                font_next = (nv < 0) ? '0 :
                                            (nv > FONT_HI) ? FONT_HI[FONT_W-1:0] : nv[FONT_W-1:0];
                            end
                            TGT_HABS: pen_x_next = nv[COORD_WIDTH-1:0];
                            TGT_HREL: pen_x_next = sat(SW'(pen_x_reg) + nv);
                            TGT_VABS: pen_y_next = nv[COORD_WIDTH-1:0];
                            TGT_VREL: pen_y_next = sat(SW'(pen_y_reg) + nv);
                            TGT_PAGE:
                            begin
                                res_v[cnt_v[0]] = mk_res(EV_PAGE, '0, '0, pen_x_next, pen_y_next,
                                    font_next, size_next,
                                    (nv < 0) ? '0 :
                                    (nv > PAGE_HI) ? PAGE_HI[PAGE_W-1:0] : nv[PAGE_W-1:0]);
                                cnt_v = cnt_v + 2'd1;
                            end
                            default: ;
                        endcase
                        do_cmd = 1'b1;
                    end
                    else
                    begin
                        res_v[cnt_v[0]] = mk_res(EV_ERROR, '0, '0, pen_x_next, pen_y_next,
                                                 font_next, size_next, '0);
                        cnt_v       = cnt_v + 2'd1;
                        halted_next = 1'b1;
                    end
                end
                default:
                begin
                    do_cmd = 1'b1;
                end
            endcase

            if (do_cmd)
            begin
                mode_next = MODE_CMD;
                if (is_digit)
                begin
                    tens_next = dval;
                    mode_next = MODE_MOTION;
                end
                else
                begin
                    case (byte_in)
                        CH_LW:
                        begin
                            res_v[cnt_v[0]] = mk_res(EV_SPACE, '0, '0, pen_x_next, pen_y_next,
                                                     font_next, size_next, '0);
                            cnt_v = cnt_v + 2'd1;
                        end
                        CH_LC: mode_next = MODE_CHAR;
                        CH_UC:
                        begin
                            name_next = '0;
                            len_next  = '0;
                            mode_next = MODE_NAME_WS;
                        end
                        CH_UD, CH_LX, CH_HASH, CH_BANG: mode_next = MODE_SKIP;
                        CH_LS, CH_LF, CH_UH, CH_LH, CH_UV, CH_LV, CH_LP:
                        begin
                            case (byte_in)
                                CH_LS:   tgt_next = TGT_SIZE;
                                CH_LF:   tgt_next = TGT_FONT;
                                CH_UH:   tgt_next = TGT_HABS;
                                CH_LH:   tgt_next = TGT_HREL;
                                CH_UV:   tgt_next = TGT_VABS;
                                CH_LV:   tgt_next = TGT_VREL;
                                default: tgt_next = TGT_PAGE;
                            endcase
                            if (byte_in == CH_LP)
                            begin
                                pen_x_next = '0;
                                pen_y_next = '0;
                            end
                            val_next  = '0;
                            neg_next  = 1'b0;
                            seen_next = 1'b0;
                            mode_next = MODE_NUM_WS;
                        end
                        CH_LN:
                        begin
                            pen_x_next = '0;
                            res_v[cnt_v[0]] = mk_res(EV_NEWLINE, '0, '0, pen_x_next, pen_y_next,
                                                     font_next, size_next, '0);
                            cnt_v     = cnt_v + 2'd1;
                            mode_next = MODE_SKIP;
                        end
                        default: ;
                    endcase
                end
            end
        end

        if (cnt_v == 2'd1)
        begin
            res_v[0].last = 1'b1;
        end
        else if (cnt_v == 2'd2)
        begin
            res_v[1].last = 1'b1;
        end
    end

    assign res0    = res_v[0];
    assign res1    = res_v[1];
    assign res_cnt = cnt_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_CMD;
            tgt_reg    <= TGT_NONE;
            font_reg   <= FONT_W'(1);
            size_reg   <= SIZE_W'(10);
            pen_x_reg  <= '0;
            pen_y_reg  <= '0;
            val_reg    <= '0;
            neg_reg    <= 1'b0;
            seen_reg   <= 1'b0;
            tens_reg   <= '0;
            name_reg   <= '0;
            len_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            tgt_reg    <= tgt_next;
            font_reg   <= font_next;
            size_reg   <= size_next;
            pen_x_reg  <= pen_x_next;
            pen_y_reg  <= pen_y_next;
            val_reg    <= val_next;
            neg_reg    <= neg_next;
            seen_reg   <= seen_next;
            tens_reg   <= tens_next;
            name_reg   <= name_next;
            len_reg    <= len_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// ===== design/dop_outq.sv =====
// Result queue of the ditroff output parser: takes up to two records per cycle,
// hands out one per transaction. Depends on dop_pkg.
module dop_outq
    import dop_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_cnt,
    input  res_t       push0,
    input  res_t       push1,
    output logic       room,
    output logic       valid,
    input  logic       ready,
    output res_t       head
);

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    res_t             mem_reg [OUTQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign valid       = (count_reg != '0);
    assign room        = (count_reg <= CNT_W'(OUTQ_DEPTH - 2));
    assign pop         = valid && ready;
    assign head        = mem_reg[rd_ptr_reg];
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/ditroff_output_parser_top.sv =====
// Top level of the ditroff output parser: input register, parser core, result queue.
// Depends on dop_pkg, dop_core and dop_outq.
//
// Takes one byte of troff intermediate output per transaction and emits character,
// special character, word space, newline, new page and error events, each with the
// pen position, font and point size. While the queue has room a byte is taken every cycle: it
// is held in the input register, parsed combinationally, and its results can leave on the
// next cycle. A byte that ends a number and starts a command can give two results;
// these leave one per cycle while m_tready is high, through a four-entry queue, and
// input stalls while that queue has fewer than two free entries. After an error event
// every further byte is taken and dropped until reset.
module ditroff_output_parser_top
    import dop_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int NAME_CHARS  = NAME_CHARS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,  // [7:0] byte_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,  // char_code, special_name, x_pos, y_pos,
                                            // font_number, point_size, page_number
    output logic [TUSER_W-1:0]    m_tuser,  // event_kind
    output logic                  m_tlast
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              room;
    logic              fire;
    res_t              res0, res1, head;
    logic [1:0]        res_cnt;

    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            in_byte_reg <= s_tdata[BYTE_W-1:0];
        end
    end

    dop_core #(
        .COORD_WIDTH (COORD_WIDTH),
        .NAME_CHARS  (NAME_CHARS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .byte_in (in_byte_reg),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    dop_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (res_cnt),
        .push0    (res0),
        .push1    (res1),
        .room     (room),
        .valid    (m_tvalid),
        .ready    (m_tready),
        .head     (head)
    );

    assign m_tdata = TDATA_W'({head.page, head.size, head.font, head.y_pos, head.x_pos,
                               head.name, head.code});
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

// ===== tb/ditroff_output_parser_top_tb.sv =====
// Self-checking testbench for ditroff_output_parser_top: byte stream in, parse events out.
// Holds its own parser predictor, a directed stimulus table, and random streams of mostly well-formed commands.
// Depends on dop_pkg and the RTL under design/.
module ditroff_output_parser_top_tb;
    import dop_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 1300;
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_LEN    = 130;

    localparam int O_NAME = CODE_W;
    localparam int O_X    = O_NAME + NAME_OUT_W;
    localparam int O_Y    = O_X + POS_W;
    localparam int O_FONT = O_Y + POS_W;
    localparam int O_SIZE = O_FONT + FONT_W;
    localparam int O_PAGE = O_SIZE + SIZE_W;

    localparam longint PEN_MAX = (longint'(1) << (COORD_WIDTH_DEF - 1)) - 1;
    localparam longint PEN_MIN = -PEN_MAX - 1;

    localparam logic [7:0] K_CHAR    = "c";
    localparam logic [7:0] K_NAMED   = "C";
    localparam logic [7:0] K_WORD    = "w";
    localparam logic [7:0] K_NEWLINE = "n";
    localparam logic [7:0] K_PAGE    = "p";
    localparam logic [7:0] K_SIZE    = "s";
    localparam logic [7:0] K_FONT    = "f";
    localparam logic [7:0] K_HABS    = "H";
    localparam logic [7:0] K_HREL    = "h";
    localparam logic [7:0] K_VABS    = "V";
    localparam logic [7:0] K_VREL    = "v";
    localparam logic [7:0] K_DRAW    = "D";
    localparam logic [7:0] K_DEVICE  = "x";
    localparam logic [7:0] K_COMMENT = "#";
    localparam logic [7:0] K_TRANSP  = "!";
    localparam logic [7:0] B_PLUS    = "+";
    localparam logic [7:0] B_MINUS   = "-";
    localparam logic [7:0] B_ZERO    = "0";
    localparam logic [7:0] B_NINE    = "9";
    localparam logic [7:0] B_SP      = 8'h20;
    localparam logic [7:0] B_TAB     = 8'h09;
    localparam logic [7:0] B_NL      = 8'h0a;
    localparam logic [7:0] B_VT      = 8'h0b;
    localparam logic [7:0] B_FF      = 8'h0c;
    localparam logic [7:0] B_CR      = 8'h0d;

    typedef enum logic [3:0] {
        P_CMD, P_MOTION, P_CHAR, P_NAME_WS, P_NAME, P_SKIP, P_NUM_WS, P_NUM_BODY
    } parse_state_t;

    typedef struct {
        logic [7:0] b;
        bit         typed;
        res_t       want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic [TUSER_W-1:0]    m_tuser;
    logic                  m_tlast;

    // parser predictor state
    parse_state_t pm;
    longint       font_now, size_now, pen_x, pen_y, num_mag, tens;
    bit           num_neg, num_digit, halted;
    logic [63:0]  name_acc;
    int           name_len;
    logic [7:0]   num_cmd;
    res_t         step_out [2];
    int           step_cnt;

    res_t         pending_events [$];
    stim_row_t    dir_rows [$];
    logic [7:0]   burst [$];

    int  mismatches = 0;
    int  n_bytes = 0;
    int  n_events = 0;
    int  kind_seen [6];
    int  tx_gap_pct = 0;
    int  rx_stall_pct = 0;
    bit  hold_req = 1'b0;
    int  quiet_cycles = 0;

    ditroff_output_parser_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic bit is_ws(logic [7:0] b);
        return b == B_SP || b == B_TAB || b == B_NL || b == B_VT || b == B_FF || b == B_CR;
    endfunction

    function automatic bit is_dig(logic [7:0] b);
        return b >= B_ZERO && b <= B_NINE;
    endfunction

    function automatic logic [7:0] digit(int n);
        return B_ZERO + 8'(n);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void reset_model();
        pm        = P_CMD;
        font_now  = 1;
        size_now  = 10;
        pen_x     = 0;
        pen_y     = 0;
        num_mag   = 0;
        num_neg   = 1'b0;
        num_digit = 1'b0;
        tens      = 0;
        name_acc  = '0;
        name_len  = 0;
        halted    = 1'b0;
        num_cmd   = '0;
    endfunction

    function automatic void emit(ev_kind_t k, logic [7:0] code, logic [63:0] nm, longint page);
        res_t r;
        r        = '0;
        r.kind   = k;
        r.code   = code;
        r.name   = nm;
        r.x_pos  = pen_x[POS_W-1:0];
        r.y_pos  = pen_y[POS_W-1:0];
        r.font   = font_now[FONT_W-1:0];
        r.size   = size_now[SIZE_W-1:0];
        r.page   = page[PAGE_W-1:0];
        r.last   = 1'b0;
        step_out[step_cnt] = r;
        step_cnt++;
    endfunction

    function automatic void start_number(logic [7:0] cmd);
        num_cmd   = cmd;
        num_mag   = 0;
        num_neg   = 1'b0;
        num_digit = 1'b0;
        pm        = P_NUM_WS;
    endfunction

    function automatic void add_digit(logic [7:0] b);
        longint d;
        d = longint'(b) - longint'(B_ZERO);
        if (num_mag > (PEN_MAX - d) / 10)
            num_mag = PEN_MAX;
        else
            num_mag = num_mag * 10 + d;
        num_digit = 1'b1;
    endfunction

    function automatic void stop_on_error();
        emit(EV_ERROR, 8'h00, 64'd0, 0);
        halted = 1'b1;
    endfunction

    function automatic void take_command(logic [7:0] b);
        pm = P_CMD;
        if (is_dig(b))
        begin
            tens = longint'(b) - longint'(B_ZERO);
            pm   = P_MOTION;
        end
        else
        begin
            case (b)
                K_WORD:    emit(EV_SPACE, 8'h00, 64'd0, 0);
                K_CHAR:    pm = P_CHAR;
                K_NAMED:
                begin
                    name_acc = '0;
                    name_len = 0;
                    pm       = P_NAME_WS;
                end
                K_DRAW, K_DEVICE, K_COMMENT, K_TRANSP: pm = P_SKIP;
                K_SIZE, K_FONT, K_HABS, K_HREL, K_VABS, K_VREL: start_number(b);
                K_PAGE:
                begin
                    pen_x = 0;
                    pen_y = 0;
                    start_number(b);
                end
                K_NEWLINE:
                begin
                    pen_x = 0;
                    emit(EV_NEWLINE, 8'h00, 64'd0, 0);
                    pm = P_SKIP;
                end
                default: ;
            endcase
        end
    endfunction

    function automatic void apply_number();
        longint v;
        v = num_neg ? -num_mag : num_mag;
        case (num_cmd)
            K_SIZE: size_now = clamp(v, 0, 1023);
            K_FONT: font_now = clamp(v, 0, 255);
            K_HABS: pen_x = v;
            K_HREL: pen_x = clamp(pen_x + v, PEN_MIN, PEN_MAX);
            K_VABS: pen_y = v;
            K_VREL: pen_y = clamp(pen_y + v, PEN_MIN, PEN_MAX);
            K_PAGE: emit(EV_PAGE, 8'h00, 64'd0, clamp(v, 0, 65535));
            default: ;
        endcase
    endfunction

    // advance the predictor by one accepted byte and queue the events it causes
    function automatic void parse_byte(logic [7:0] b);
        step_cnt = 0;
        if (!halted)
        begin
            case (pm)
                P_MOTION:
                begin
                    pen_x = clamp(pen_x + tens * 10 + longint'(b) - longint'(B_ZERO),
                                  PEN_MIN, PEN_MAX);
                    pm = P_CHAR;
                end
                P_CHAR:
                begin
                    emit(EV_CHAR, b, 64'd0, 0);
                    pm = P_CMD;
                end
                P_NAME_WS:
                begin
                    if (!is_ws(b))
                    begin
                        name_acc = {56'd0, b};
                        name_len = 1;
                        pm       = P_NAME;
                    end
                end
                P_NAME:
                begin
                    if (is_ws(b))
                    begin
                        emit(EV_SPECIAL, 8'h00, name_acc, 0);
                        pm = P_CMD;
                    end
                    else if (name_len < NAME_CHARS_DEF)
                    begin
                        name_acc[8 * name_len +: 8] = b;
                        name_len++;
                    end
                end
                P_SKIP:
                begin
                    if (b == B_NL)
                        pm = P_CMD;
                end
                P_NUM_WS:
                begin
                    if (is_ws(b))
                        ;
                    else if (b == B_PLUS || b == B_MINUS)
                    begin
                        num_neg = (b == B_MINUS);
                        pm      = P_NUM_BODY;
                    end
                    else if (is_dig(b))
                    begin
                        add_digit(b);
                        pm = P_NUM_BODY;
                    end
                    else
                        stop_on_error();
                end
                P_NUM_BODY:
                begin
                    if (is_dig(b))
                        add_digit(b);
                    else if (num_digit)
                    begin
                        pm = P_CMD;
                        apply_number();
                        take_command(b);
                    end
                    else
                        stop_on_error();
                end
                default: take_command(b);
            endcase
        end
        if (step_cnt > 0)
            step_out[step_cnt - 1].last = 1'b1;
        for (int i = 0; i < step_cnt; i++)
            pending_events.push_back(step_out[i]);
    endfunction

    function automatic res_t home_event(ev_kind_t k, logic [7:0] code);
        res_t r;
        r      = '0;
        r.kind = k;
        r.code = code;
        r.font = 8'd1;
        r.size = 10'd10;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void add_row(logic [7:0] b, bit typed = 1'b0, res_t want = '0);
        stim_row_t row;
        row.b     = b;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    function automatic void build_rows();
        add_row(K_CHAR);
        add_row(8'hFF, 1'b1, home_event(EV_CHAR, 8'hFF));
        add_row(K_CHAR);
        add_row(8'h00, 1'b1, home_event(EV_CHAR, 8'h00));
        add_row(K_WORD, 1'b1, home_event(EV_SPACE, 8'h00));
        // page number clamps; w both ends the number and is a command
        add_row(K_PAGE);
        for (int i = 0; i < 5; i++)
            add_row(digit(7));
        add_row(K_WORD);
        add_row(K_SIZE);
        add_row(B_PLUS);
        add_row(digit(2));
        for (int i = 0; i < 3; i++)
            add_row(digit(0));
        add_row(K_FONT);
        add_row(B_MINUS);
        add_row(digit(3));
        add_row(K_VREL);
        add_row(B_MINUS);
        add_row(digit(4));
        add_row(B_SP);
        // motion whose units byte is not a digit
        add_row(digit(1));
        add_row(8'hFF);
        add_row("A");
        add_row(K_NAMED);
        add_row(B_TAB);
        add_row("s");
        add_row("q");
        add_row(B_NL);
        add_row(K_NEWLINE);
        add_row("z");
        add_row(B_NL);
        add_row(K_COMMENT);
        add_row(B_NL);
    endfunction

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 5))
            0:       return B_SP;
            1:       return B_TAB;
            2:       return B_NL;
            3:       return B_VT;
            4:       return B_FF;
            default: return B_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_number_cmd();
        case ($urandom_range(0, 6))
            0:       return K_SIZE;
            1:       return K_FONT;
            2:       return K_HABS;
            3:       return K_HREL;
            4:       return K_VABS;
            5:       return K_VREL;
            default: return K_PAGE;
        endcase
    endfunction

    function automatic logic [7:0] pick_skip_cmd();
        case ($urandom_range(0, 3))
            0:       return K_DRAW;
            1:       return K_DEVICE;
            2:       return K_COMMENT;
            default: return K_TRANSP;
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_solid();
        logic [7:0] b;
        do
            b = ($urandom_range(0, 3) == 0) ? rand_byte() : 8'($urandom_range(33, 126));
        while (is_ws(b));
        return b;
    endfunction

    function automatic logic [7:0] rand_not_nl();
        logic [7:0] b;
        do
            b = rand_byte();
        while (b == B_NL);
        return b;
    endfunction

    // one well-formed command with random content, or a little noise
    function automatic void make_burst();
        int sel;
        int nd;
        sel = $urandom_range(0, 99);
        burst.delete();
        if (sel < 30)
        begin
            burst.push_back(pick_number_cmd());
            if ($urandom_range(0, 3) == 0)
                burst.push_back(pick_ws());
            case ($urandom_range(0, 3))
                0:       burst.push_back(B_PLUS);
                1:       burst.push_back(B_MINUS);
                default: ;
            endcase
            nd = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 3);
            repeat (nd)
                burst.push_back(digit($urandom_range(0, 9)));
            if ($urandom_range(0, 1) == 0)
                burst.push_back(pick_ws());
        end
        else if (sel < 50)
        begin
            burst.push_back(K_CHAR);
            burst.push_back(rand_byte());
        end
        else if (sel < 62)
        begin
            burst.push_back(digit($urandom_range(0, 9)));
            burst.push_back(($urandom_range(0, 4) == 0) ? rand_byte()
                                                        : digit($urandom_range(0, 9)));
            burst.push_back(rand_byte());
        end
        else if (sel < 70)
        begin
            burst.push_back(K_NAMED);
            if ($urandom_range(0, 1) == 0)
                burst.push_back(pick_ws());
            nd = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
            repeat (nd)
                burst.push_back(rand_solid());
            burst.push_back(pick_ws());
        end
        else if (sel < 76)
            burst.push_back(K_WORD);
        else if (sel < 86)
        begin
            burst.push_back((sel < 80) ? K_NEWLINE : pick_skip_cmd());
            repeat ($urandom_range(0, 6))
                burst.push_back(rand_not_nl());
            burst.push_back(B_NL);
        end
        else if (sel < 90)
            burst.push_back(pick_ws());
        else
        begin
            repeat ($urandom_range(1, 3))
                burst.push_back(rand_byte());
        end
    endfunction

    // swap a byte that would break a number for a digit
    function automatic logic [7:0] keep_number_valid(logic [7:0] b);
        if (pm == P_NUM_WS && !is_ws(b) && b != B_PLUS && b != B_MINUS && !is_dig(b))
            return digit($urandom_range(0, 9));
        if (pm == P_NUM_BODY && !num_digit && !is_dig(b))
            return digit($urandom_range(0, 9));
        return b;
    endfunction

    function automatic logic [7:0] settle_byte();
        case (pm)
            P_MOTION, P_NUM_WS: return B_ZERO;
            P_NUM_BODY:         return num_digit ? B_SP : B_ZERO;
            P_NAME_WS:          return K_WORD;
            P_NAME:             return B_SP;
            P_SKIP:             return B_NL;
            default:            return rand_byte();
        endcase
    endfunction

    function automatic void set_idle_phase(int n);
        case ((n / PHASE_LEN) % 5)
            1:
            begin
                tx_gap_pct   = 46;
                rx_stall_pct = 0;
            end
            2:
            begin
                tx_gap_pct   = 0;
                rx_stall_pct = 46;
            end
            3:
            begin
                tx_gap_pct   = 9;
                rx_stall_pct = 9;
            end
            default:
            begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        parse_byte(b);
        n_bytes++;
        @(negedge clk);
    endtask

    function automatic void check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", fname, want, got);
            mismatches++;
        end
    endfunction

    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        res_t want;
        res_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind  = ev_kind_t'(m_tuser);
            got.code  = m_tdata[0 +: CODE_W];
            got.name  = m_tdata[O_NAME +: NAME_OUT_W];
            got.x_pos = m_tdata[O_X +: POS_W];
            got.y_pos = m_tdata[O_Y +: POS_W];
            got.font  = m_tdata[O_FONT +: FONT_W];
            got.size  = m_tdata[O_SIZE +: SIZE_W];
            got.page  = m_tdata[O_PAGE +: PAGE_W];
            got.last  = m_tlast;
            n_events++;
            if (m_tuser < 6)
                kind_seen[m_tuser]++;
            if (pending_events.size() == 0)
            begin
                $error("event with nothing pending: event_kind %0d", m_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_events.pop_front();
                check_field("event_kind", 64'(want.kind), 64'(got.kind));
                check_field("char_code", 64'(want.code), 64'(got.code));
                check_field("special_name", want.name, got.name);
                check_field("x_pos", 64'(want.x_pos), 64'(got.x_pos));
                check_field("y_pos", 64'(want.y_pos), 64'(got.y_pos));
                check_field("font_number", 64'(want.font), 64'(got.font));
                check_field("point_size", 64'(want.size), 64'(got.size));
                check_field("page_number", 64'(want.page), 64'(got.page));
                check_field("last", 64'(want.last), 64'(got.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Timeout: no transaction for %0d cycles, %0d events pending",
                 QUIET_LIMIT, pending_events.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int  target;
        bit  hold_done;
        bit  pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        for (int i = 0; i < 6; i++)
            kind_seen[i] = 0;
        reset_model();
        build_rows();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            send_byte(dir_rows[i].b);
            if (dir_rows[i].typed)
            begin
                void'(pending_events.pop_back());
                pending_events.push_back(dir_rows[i].want);
            end
        end

        target = n_bytes + RANDOM_BYTES;
        while (n_bytes < target)
        begin
            set_idle_phase(n_bytes);
            if (!hold_done && n_bytes >= 500)
            begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            if (!pause_done && n_bytes >= 900)
            begin
                pause_done = 1'b1;
                s_tvalid <= 1'b0;
                while (pending_events.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            make_burst();
            foreach (burst[i])
                send_byte(keep_number_valid(burst[i]));
        end

        // finish with a malformed number, then bytes that must be dropped
        set_idle_phase(0);
        while (pm != P_CMD)
            send_byte(settle_byte());
        if ($urandom_range(0, 1) == 0)
        begin
            send_byte(K_SIZE);
            send_byte(K_WORD);
        end
        else
        begin
            send_byte(K_FONT);
            send_byte(B_MINUS);
            send_byte(K_WORD);
        end
        repeat (8)
            send_byte(rand_byte());
        s_tvalid <= 1'b0;

        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d bytes and %0d events: %0d char, %0d special, %0d space,",
                 n_bytes, n_events, kind_seen[EV_CHAR], kind_seen[EV_SPECIAL],
                 kind_seen[EV_SPACE]);
        $display("  %0d newline, %0d new page, %0d error; %0d mismatches",
                 kind_seen[EV_NEWLINE], kind_seen[EV_PAGE], kind_seen[EV_ERROR], mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
design/dop_pkg.sv
design/dop_core.sv
design/dop_outq.sv
design/ditroff_output_parser_top.sv
tb/ditroff_output_parser_top_tb.sv
